/* rtl/core/fts_pkg.sv */
package fts_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 11;
    localparam int NODE_W  = 12;
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [CMD_W-1:0] CMD_POINT_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RANGE_ADD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RANGE_SUM = 2'd3;

    // two walks per request: walk a adds, walk b subtracts; index 0 skips a walk
    typedef struct packed {
        logic              is_query;
        logic [NODE_W-1:0] idx_a;
        logic [NODE_W-1:0] idx_b;
        logic [SUM_W-1:0]  amount;
    } op_t;

endpackage

/* rtl/core/fts_front.sv */
module fts_front (
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fts_pkg::CMD_W-1:0]      cmd,
    input  logic [fts_pkg::IDX_W-1:0]      first_index,
    input  logic [fts_pkg::IDX_W-1:0]      last_index,
    input  logic signed [fts_pkg::DELTA_W-1:0] delta,
    input  logic [fts_pkg::IDX_W-1:0]      eff_size,
    input  logic                           q_full,
    input  logic                           clearing,
    output logic                           push,
    output fts_pkg::op_t                   op
);
    import fts_pkg::*;

    logic              bad_range;
    logic [IDX_W-1:0]  lo_m1;
    logic [IDX_W-1:0]  hi_sat;
    logic [IDX_W-1:0]  lo_m1_sat;
    logic [NODE_W-1:0] lo_ext;
    logic [NODE_W-1:0] hi_plus1;

    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        bad_range = (first_index == '0) || (last_index == '0) || (first_index > last_index);
        lo_m1     = first_index - 1'b1;
        hi_sat    = (last_index > eff_size) ? eff_size : last_index;
        lo_m1_sat = (lo_m1 > eff_size) ? eff_size : lo_m1;
        lo_ext    = {1'b0, first_index};
        hi_plus1  = {1'b0, last_index} + 12'd1;

        op.amount   = SUM_W'(delta);
        op.is_query = 1'b0;
        op.idx_a    = '0;
        op.idx_b    = '0;
        unique case (cmd)
            CMD_POINT_ADD:
            begin
                op.idx_a = lo_ext;
            end
            CMD_RANGE_ADD:
            begin
                op.idx_a = bad_range ? '0 : lo_ext;
                op.idx_b = bad_range ? '0 : hi_plus1;
            end
            CMD_PREFIX:
            begin
                op.is_query = 1'b1;
                op.idx_a    = {1'b0, hi_sat};
            end
            CMD_RANGE_SUM:
            begin
                op.is_query = 1'b1;
                op.idx_a    = bad_range ? '0 : {1'b0, hi_sat};
                op.idx_b    = bad_range ? '0 : {1'b0, lo_m1_sat};
            end
            default:
            begin
                op.idx_a = '0;
            end
        endcase
    end

endmodule

/* rtl/core/fts_queue.sv */
module fts_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  fts_pkg::op_t push_op,
    input  logic         pop,
    output fts_pkg::op_t head_op,
    output logic         not_empty,
    output logic         full
);
    import fts_pkg::*;

    op_t                    buf_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign head_op   = buf_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/core/fts_back.sv */
module fts_back #(
    parameter int SIZE = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [fts_pkg::IDX_W-1:0] eff_size,
    input  logic                      q_valid,
    input  fts_pkg::op_t              q_op,
    output logic                      q_pop,
    output logic                      clearing,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [fts_pkg::SUM_W-1:0] sum
);
    import fts_pkg::*;

    localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(SIZE - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_WALK_A = 3'd2;
    localparam logic [2:0] S_WALK_B = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [SUM_W-1:0] mem [SIZE];

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [NODE_W-1:0] idx_reg, idx_next;
    op_t               op_reg, op_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic              pend_reg, pend_next;
    logic              pend_neg_reg, pend_neg_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              res_valid_reg, res_valid_next;
    logic [SUM_W-1:0]  res_reg, res_next;
    logic [SUM_W-1:0]  rdata_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              we;
    logic [AW-1:0]     wa;
    logic [SUM_W-1:0]  wd;
    logic              node_ok;
    logic [NODE_W-1:0] idx_m1;
    logic [NODE_W-1:0] low_bit;
    logic [AW-1:0]     step_addr;

    assign clearing  = (state_reg == S_CLEAR);
    assign out_valid = res_valid_reg;
    assign sum       = res_reg;

    always_comb
    begin
        node_ok   = (idx_reg != '0) && (idx_reg <= {1'b0, eff_size});
        idx_m1    = idx_reg - 1'b1;
        low_bit   = idx_reg & (~idx_reg + 1'b1);
        step_addr = AW'(idx_m1);

        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        pend_neg_next  = pend_neg_reg;
        pend_addr_next = pend_addr_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = step_addr;
        we             = 1'b0;
        wa             = pend_addr_reg;
        wd             = '0;
        q_pop          = 1'b0;

        // finish the node read in the previous cycle
        if (pend_reg)
        begin
            if (op_reg.is_query)
            begin
                acc_next = pend_neg_reg ? acc_reg - rdata_reg : acc_reg + rdata_reg;
            end
            else
            begin
                we = 1'b1;
                wd = pend_neg_reg ? rdata_reg - op_reg.amount : rdata_reg + op_reg.amount;
            end
        end

        if (res_valid_reg && out_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            S_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_op;
                    idx_next   = q_op.idx_a;
                    acc_next   = '0;
                    state_next = S_WALK_A;
                end
            end
            S_WALK_A, S_WALK_B:
            begin
                pend_neg_next = (state_reg == S_WALK_B);
                if (node_ok)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = step_addr;
                    idx_next       = op_reg.is_query ? (idx_reg & idx_m1) : (idx_reg + low_bit);
                end
                else if (state_reg == S_WALK_A)
                begin
                    // this idle step lets the last write of walk a land first
                    idx_next   = op_reg.idx_b;
                    state_next = S_WALK_B;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || out_ready)
                begin
                    res_valid_next = 1'b1;
                    res_next       = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        op_reg        <= op_next;
        acc_reg       <= acc_next;
        pend_neg_reg  <= pend_neg_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("node read still pending in idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !op_reg.is_query) |-> (acc_reg == '0))
        else $error("update request carries a nonzero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("request taken during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ($past(state_reg) == S_WALK_A || $past(state_reg) == S_WALK_B))
        else $error("node read issued outside a walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        (we && rd_en) |-> (wa != rd_addr))
        else $error("read of a node with a write in flight");

endmodule

/* rtl/core/fenwick_tree_sum_engine_core.sv */
// each request runs two walks, each visiting tree nodes (up to 11 for 1024 entries);
// a two-entry queue takes new requests while the back end finishes one at a time,
// one node per cycle over the single read port and single write port of the
// node memory
// reset: all control cleared, then a clearing pass zeroes every node memory word
// while in_ready stays low; active_size resets to 1024
module fenwick_tree_sum_engine_core #(
    parameter int SIZE = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fts_pkg::IDX_W-1:0]         active_size,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fts_pkg::CMD_W-1:0]         cmd,
    input  logic [fts_pkg::IDX_W-1:0]         first_index,
    input  logic [fts_pkg::IDX_W-1:0]         last_index,
    input  logic signed [fts_pkg::DELTA_W-1:0] delta,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fts_pkg::SUM_W-1:0]  sum
);
    import fts_pkg::*;

    logic [IDX_W-1:0] active_size_reg;
    logic [IDX_W-1:0] eff_size;
    logic             push;
    op_t              push_op;
    op_t              head_op;
    logic             q_valid;
    logic             q_full;
    logic             q_pop;
    logic             clearing;

    assign cfg_ready = 1'b1;
    assign eff_size  = ({21'b0, active_size_reg} > 32'(SIZE)) ? IDX_W'(SIZE) : active_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= 11'd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_size_reg <= active_size;
        end
    end

    fts_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .first_index (first_index),
        .last_index  (last_index),
        .delta       (delta),
        .eff_size    (eff_size),
        .q_full      (q_full),
        .clearing    (clearing),
        .push        (push),
        .op          (push_op)
    );

    fts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (q_pop),
        .head_op   (head_op),
        .not_empty (q_valid),
        .full      (q_full)
    );

    fts_back #(
        .SIZE (SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_size  (eff_size),
        .q_valid   (q_valid),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum       (sum)
    );

endmodule

/* tb/tb_fenwick_tree_sum_engine_core.sv */
module tb_fenwick_tree_sum_engine_core;
    import fts_pkg::*;

    localparam int TREE_SIZE   = 1024;
    localparam int MAX_INDEX   = 2047;
    localparam int LONG_HOLD   = 600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [IDX_W-1:0]   first_idx;
        logic [IDX_W-1:0]   last_idx;
        logic [DELTA_W-1:0] amount;
    } tree_req_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          active_size = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic [CMD_W-1:0]          cmd         = CMD_POINT_ADD;
    logic [IDX_W-1:0]          first_index = '0;
    logic [IDX_W-1:0]          last_index  = '0;
    logic signed [DELTA_W-1:0] delta       = '0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic signed [SUM_W-1:0]   sum;

    fenwick_tree_sum_engine_core #(
        .SIZE(TREE_SIZE)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .active_size (active_size),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .first_index (first_index),
        .last_index  (last_index),
        .delta       (delta),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sum         (sum)
    );

    logic [SUM_W-1:0] node_sums [1:TREE_SIZE];
    int               size_setting;
    tree_req_t        req_queue [$];
    logic [SUM_W-1:0] pending_sums [$];
    logic [IDX_W-1:0] size_writes [$];
    tree_req_t        live_req;
    logic [SUM_W-1:0] expected_sum;
    int               reqs_queued;
    int               reqs_accepted;
    int               size_writes_queued;
    int               size_writes_done;
    int               send_wait;
    int               stall_left;
    int               hold_left;
    int               recv_gap;
    bit               send_idle_on;
    bit               recv_idle_on;
    bit               hold_arm;
    bit               hold_done;
    int               bad_results;
    int               cycle_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int eff_entries();
        return (size_setting > TREE_SIZE) ? TREE_SIZE : size_setting;
    endfunction

    function automatic void tree_add(input int unsigned pos, input logic [SUM_W-1:0] amt);
        int unsigned n;
        n = eff_entries();
        if (pos == 0)
            return;
        while (pos <= n)
        begin
            node_sums[pos] += amt;
            pos += pos & (~pos + 1);
        end
    endfunction

    function automatic logic [SUM_W-1:0] prefix_total(input int unsigned pos);
        int unsigned      n;
        logic [SUM_W-1:0] acc;
        n = eff_entries();
        acc = '0;
        if (pos > n)
            pos = n;
        while (pos != 0)
        begin
            acc += node_sums[pos];
            pos &= pos - 1;
        end
        return acc;
    endfunction

    function automatic logic [SUM_W-1:0] apply_request(input tree_req_t r);
        logic [SUM_W-1:0] amt;
        logic [SUM_W-1:0] total;
        logic             bad_range;
        amt = {{(SUM_W - DELTA_W){r.amount[DELTA_W-1]}}, r.amount};
        total = '0;
        bad_range = (r.first_idx == 0) || (r.last_idx == 0) || (r.first_idx > r.last_idx);
        case (r.op)
            CMD_POINT_ADD:
                tree_add(32'(r.first_idx), amt);
            CMD_RANGE_ADD:
                if (!bad_range)
                begin
                    tree_add(32'(r.first_idx), amt);
                    tree_add(int'(r.last_idx) + 1, -amt);
                end
            CMD_PREFIX:
                total = prefix_total(32'(r.last_idx));
            CMD_RANGE_SUM:
                if (!bad_range)
                    total = prefix_total(32'(r.last_idx)) - prefix_total(int'(r.first_idx) - 1);
        endcase
        return total;
    endfunction

    function automatic int draw_gap(input bit enabled);
        if (!enabled || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic int pick_index();
        int n;
        int r;
        n = eff_entries();
        r = $urandom_range(0, 99);
        if (r < 4)
            return 0;
        if (r < 12)
            return $urandom_range(0, MAX_INDEX);
        if (r < 18)
            return n + $urandom_range(0, 2);
        return $urandom_range(1, (n < 1) ? 1 : n);
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return DELTA_W'($urandom_range(0, 200) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_req(input logic [CMD_W-1:0] op, input int first, input int last,
                             input logic [DELTA_W-1:0] amt);
        tree_req_t r;
        r.op        = op;
        r.first_idx = IDX_W'(first);
        r.last_idx  = IDX_W'(last);
        r.amount    = amt;
        req_queue.insert(req_queue.size(), r);
        reqs_queued++;
    endtask

    task automatic wait_drained();
        while (reqs_accepted != reqs_queued || pending_sums.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_size(input int value);
        wait_drained();
        size_writes.insert(size_writes.size(), IDX_W'(value));
        size_writes_queued++;
        while (size_writes_done != size_writes_queued)
            @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        logic [CMD_W-1:0] op;
        int               a;
        int               b;
        int               t;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: op = CMD_POINT_ADD;
                1: op = CMD_RANGE_ADD;
                2: op = CMD_PREFIX;
                default: op = CMD_RANGE_SUM;
            endcase
            a = pick_index();
            b = pick_index();
            // mostly well-ordered ranges
            if (a > b && $urandom_range(0, 9) < 8)
            begin
                t = a;
                a = b;
                b = t;
            end
            queue_req(op, a, b, pick_delta());
        end
        wait_drained();
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            cmd         <= CMD_POINT_ADD;
            first_index <= '0;
            last_index  <= '0;
            delta       <= '0;
            send_wait   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_sums.insert(pending_sums.size(), apply_request(live_req));
                reqs_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    in_valid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (req_queue.size() > 0)
                begin
                    live_req = req_queue.pop_front();
                    cmd         <= live_req.op;
                    first_index <= live_req.first_idx;
                    last_index  <= live_req.last_idx;
                    delta       <= live_req.amount;
                    in_valid    <= 1'b1;
                    send_wait   <= draw_gap(send_idle_on);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // size register writer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid   <= 1'b0;
            active_size <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid <= 1'b0;
            size_setting = int'(active_size);
            size_writes_done++;
        end
        else if (!cfg_valid && size_writes.size() > 0)
        begin
            active_size <= size_writes.pop_front();
            cfg_valid   <= 1'b1;
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_arm && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            out_ready <= (hold_left == 1);
            hold_left <= hold_left - 1;
        end
        else if (out_valid && out_ready)
        begin
            recv_gap = draw_gap(recv_idle_on);
            out_ready  <= (recv_gap == 0);
            stall_left <= recv_gap;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= (stall_left == 1);
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_sums.size() == 0)
            begin
                if (bad_results < MAX_REPORTS)
                    $display("unexpected result: sum %h", sum);
                bad_results++;
            end
            else
            begin
                expected_sum = pending_sums.pop_front();
                if (sum !== expected_sum)
                begin
                    if (bad_results < MAX_REPORTS)
                        $display("sum mismatch: expected %h, actual %h", expected_sum, sum);
                    bad_results++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        size_setting = TREE_SIZE;
        for (int i = 1; i <= TREE_SIZE; i++)
            node_sums[i] = '0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // edge cases at the reset size
        queue_req(CMD_POINT_ADD, 1, 0, 32'h7fff_ffff);
        queue_req(CMD_POINT_ADD, TREE_SIZE, 0, 32'h8000_0000);
        queue_req(CMD_POINT_ADD, 0, 5, 77);
        queue_req(CMD_POINT_ADD, MAX_INDEX, MAX_INDEX, 5);
        queue_req(CMD_RANGE_ADD, 3, 7, -100);
        queue_req(CMD_RANGE_ADD, 0, 5, 9);
        queue_req(CMD_RANGE_ADD, 9, 4, 9);
        queue_req(CMD_RANGE_ADD, 1000, TREE_SIZE, 1234567);
        queue_req(CMD_RANGE_ADD, 5, MAX_INDEX, 32'h8000_0000);
        queue_req(CMD_RANGE_ADD, 1, 1, '1);
        queue_req(CMD_PREFIX, 0, 0, 0);
        queue_req(CMD_PREFIX, 0, 1, 0);
        queue_req(CMD_PREFIX, MAX_INDEX, TREE_SIZE, 0);
        queue_req(CMD_PREFIX, 0, MAX_INDEX, 0);
        queue_req(CMD_PREFIX, 0, 6, 0);
        queue_req(CMD_RANGE_SUM, 3, 7, 0);
        queue_req(CMD_RANGE_SUM, 0, 7, 0);
        queue_req(CMD_RANGE_SUM, 7, 3, 0);
        queue_req(CMD_RANGE_SUM, 1, TREE_SIZE, 0);
        queue_req(CMD_RANGE_SUM, TREE_SIZE, MAX_INDEX, 0);
        queue_req(CMD_RANGE_SUM, 2, 2, 0);
        queue_req(CMD_RANGE_SUM, 5, 0, 0);
        queue_req(CMD_POINT_ADD, 512, 0, 32'h8000_0000);
        queue_req(CMD_RANGE_SUM, 500, 600, 32'h1234_5678);
        wait_drained();

        random_phase(300);

        write_size(8);
        send_idle_on = 1'b0;
        random_phase(200);

        write_size(1);
        send_idle_on = 1'b1;
        random_phase(120);

        write_size(0);
        random_phase(60);

        // receiver stalls long while requests keep coming
        write_size(MAX_INDEX);
        send_idle_on = 1'b0;
        hold_arm = 1'b1;
        random_phase(200);

        write_size(37);
        recv_idle_on = 1'b0;
        random_phase(200);

        write_size(TREE_SIZE);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        random_phase(350);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (bad_results == 0 && pending_sums.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fts_pkg.sv
rtl/core/fts_front.sv
rtl/core/fts_queue.sv
rtl/core/fts_back.sv
rtl/core/fenwick_tree_sum_engine_core.sv
tb/tb_fenwick_tree_sum_engine_core.sv
